@@ src/nlpd_pkg.sv @@
// nlpd_pkg: shared types and constants of the point deframer
`timescale 1ns / 1ps
`default_nettype none
package nlpd_pkg;

    localparam int unsigned HEAD_BYTES  = 3;
    localparam int unsigned POINT_BYTES = 4;

    typedef enum logic [3:0] {
        PH_MSG_LEN_HI = 4'd0,
        PH_MSG_LEN_LO = 4'd1,
        PH_MSG_TYPE   = 4'd2,
        PH_REC_LEN_HI = 4'd3,
        PH_REC_LEN_LO = 4'd4,
        PH_REC_TYPE   = 4'd5,
        PH_KIND       = 4'd6,
        PH_SIZE       = 4'd7,
        PH_COLOR      = 4'd8,
        PH_POINT      = 4'd9,
        PH_SKIP       = 4'd10
    } phase_t;

    typedef struct packed {
        logic [7:0]         object_kind;
        logic [7:0]         obj_size;
        logic [7:0]         obj_color;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               last_in_object;
        logic               last_in_message;
    } point_t;

    typedef struct packed {
        logic   emit;
        point_t point;
    } result_t;

endpackage
`default_nettype wire

@@ src/nlpd_byte_if.sv @@
// nlpd_byte_if: valid/ready channel carrying one stream byte per word
`timescale 1ns / 1ps
`default_nettype none
interface nlpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

@@ src/nlpd_point_if.sv @@
// nlpd_point_if: valid/ready channel carrying one decoded point per word
`timescale 1ns / 1ps
`default_nettype none
interface nlpd_point_if;
    logic               valid;
    logic               ready;
    logic [7:0]         object_kind;
    logic [7:0]         obj_size;
    logic [7:0]         obj_color;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_in_object;
    logic               last_in_message;

    modport source (
        output valid, output object_kind, output obj_size, output obj_color,
        output point_x, output point_y, output last_in_object, output last_in_message,
        input ready
    );
    modport sink (
        input valid, input object_kind, input obj_size, input obj_color,
        input point_x, input point_y, input last_in_object, input last_in_message,
        output ready
    );
endinterface
`default_nettype wire

@@ src/nlpd_parser.sv @@
// nlpd_parser: message and record parse state, one byte per cycle while accept is high
`timescale 1ns / 1ps
`default_nettype none
module nlpd_parser
    import nlpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] byte_in,
    output result_t         result
);

    localparam logic [1:0]  LAST_GATHER = 2'(HEAD_BYTES);
    localparam logic [15:0] POINT_LEN   = 16'(POINT_BYTES);

    phase_t      phase_reg, phase_next;
    logic [15:0] outer_reg, outer_next;
    logic [15:0] record_reg, record_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  size_reg, size_next;
    logic [7:0]  color_reg, color_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  index_reg, index_next;

    logic [15:0] outer_dec;
    logic [15:0] record_dec;
    logic        payload;
    phase_t      slot_phase;

    assign outer_dec  = outer_reg - 16'd1;
    assign record_dec = record_reg - 16'd1;

    // phase at the start of a point slot, seen after this byte's decrement
    always_comb
    begin
        if (record_dec == 16'd0)
            slot_phase = PH_REC_LEN_HI;
        else if (record_dec < POINT_LEN)
            slot_phase = PH_SKIP;
        else
            slot_phase = PH_POINT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MSG_LEN_HI;
            outer_reg   <= '0;
            record_reg  <= '0;
            kind_reg    <= '0;
            size_reg    <= '0;
            color_reg   <= '0;
            partial_reg <= '0;
            index_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            outer_reg   <= outer_next;
            record_reg  <= record_next;
            kind_reg    <= kind_next;
            size_reg    <= size_next;
            color_reg   <= color_next;
            partial_reg <= partial_next;
            index_reg   <= index_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        outer_next   = outer_reg;
        record_next  = record_reg;
        kind_next    = kind_reg;
        size_next    = size_reg;
        color_next   = color_reg;
        partial_next = partial_reg;
        index_next   = index_reg;
        payload      = 1'b0;

        result.emit                  = 1'b0;
        result.point.object_kind     = kind_reg;
        result.point.obj_size        = size_reg;
        result.point.obj_color       = color_reg;
        result.point.point_x         = partial_reg[23:8];
        result.point.point_y         = {partial_reg[7:0], byte_in};
        result.point.last_in_object  = (record_dec < POINT_LEN) || (outer_dec < POINT_LEN);
        result.point.last_in_message = (outer_dec <= record_dec);

        if (accept)
        begin
            case (phase_reg)
                PH_MSG_LEN_LO:
                begin
                    outer_next = outer_reg | {8'h00, byte_in};
                    phase_next = PH_MSG_TYPE;
                end
                PH_MSG_TYPE:
                begin
                    phase_next = (outer_reg != 16'd0) ? PH_REC_LEN_HI : PH_MSG_LEN_HI;
                end
                PH_REC_LEN_HI:
                begin
                    payload     = 1'b1;
                    record_next = {byte_in, 8'h00};
                    phase_next  = PH_REC_LEN_LO;
                end
                PH_REC_LEN_LO:
                begin
                    payload     = 1'b1;
                    record_next = record_reg | {8'h00, byte_in};
                    phase_next  = PH_REC_TYPE;
                end
                PH_REC_TYPE:
                begin
                    payload    = 1'b1;
                    phase_next = (record_reg != 16'd0) ? PH_KIND : PH_REC_LEN_HI;
                end
                PH_KIND:
                begin
                    payload     = 1'b1;
                    record_next = record_dec;
                    kind_next   = byte_in;
                    phase_next  = (record_dec == 16'd0) ? PH_REC_LEN_HI : PH_SIZE;
                end
                PH_SIZE:
                begin
                    payload     = 1'b1;
                    record_next = record_dec;
                    size_next   = byte_in;
                    phase_next  = (record_dec == 16'd0) ? PH_REC_LEN_HI : PH_COLOR;
                end
                PH_COLOR:
                begin
                    payload     = 1'b1;
                    record_next = record_dec;
                    color_next  = byte_in;
                    index_next  = 2'd0;
                    phase_next  = slot_phase;
                end
                PH_POINT:
                begin
                    payload     = 1'b1;
                    record_next = record_dec;
                    if (index_reg != LAST_GATHER)
                    begin
                        partial_next = {partial_reg[15:0], byte_in};
                        index_next   = index_reg + 2'd1;
                        phase_next   = (record_dec == 16'd0) ? PH_REC_LEN_HI : PH_POINT;
                    end
                    else
                    begin
                        result.emit = 1'b1;
                        index_next  = 2'd0;
                        phase_next  = slot_phase;
                    end
                end
                PH_SKIP:
                begin
                    payload     = 1'b1;
                    record_next = record_dec;
                    phase_next  = (record_dec == 16'd0) ? PH_REC_LEN_HI : PH_SKIP;
                end
                default:
                begin
                    // message length high byte, also taken for unused codes
                    outer_next = {byte_in, 8'h00};
                    phase_next = PH_MSG_LEN_LO;
                    index_next = 2'd0;
                end
            endcase

            if (payload)
            begin
                outer_next = outer_dec;
                if (outer_dec == 16'd0)
                begin
                    phase_next = PH_MSG_LEN_HI;
                    index_next = 2'd0;
                end
            end
        end
    end

`ifndef SYNTH
    a_emit_only_on_fourth_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |-> (accept && phase_reg == PH_POINT && index_reg == LAST_GATHER))
        else $error("point emitted outside the fourth point byte");

    a_point_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_POINT) |-> (record_reg != 16'd0))
        else $error("gathering a point with no record content left");

    a_skip_is_short: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (record_reg != 16'd0 && record_reg < POINT_LEN))
        else $error("skipping more than a partial point");
`endif

endmodule
`default_nettype wire

@@ src/nlpd_out_reg.sv @@
// nlpd_out_reg: result register holding one point word for the receiver
`timescale 1ns / 1ps
`default_nettype none
module nlpd_out_reg
    import nlpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire result_t  result,
    output logic          can_load,
    nlpd_point_if.source  points
);

    logic   valid_reg, valid_next;
    point_t data_reg;

    assign can_load = !valid_reg || points.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
            valid_next = accept && result.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (can_load && accept && result.emit)
            data_reg <= result.point;
    end

    assign points.valid           = valid_reg;
    assign points.object_kind     = data_reg.object_kind;
    assign points.obj_size        = data_reg.obj_size;
    assign points.obj_color       = data_reg.obj_color;
    assign points.point_x         = data_reg.point_x;
    assign points.point_y         = data_reg.point_y;
    assign points.last_in_object  = data_reg.last_in_object;
    assign points.last_in_message = data_reg.last_in_message;

endmodule
`default_nettype wire

@@ src/nested_length_prefixed_point_deframer.sv @@
// nested_length_prefixed_point_deframer: top level of the update message point deframer
//
// usage
//   bytes  : byte stream sink, one raw message byte per word (byte_in)
//   points : point source, one decoded point per word with its object's
//            kind, size and color and the last-in-object / last-in-message flags
//   a message is a 3-byte head (16-bit big-endian payload length, type byte)
//   followed by object records, each with its own 3-byte head, three attribute
//   bytes and 4-byte points (big-endian signed x then y)
//   throughput: one byte per cycle while bytes.ready is high; the parse state updates in the
//   cycle a byte is taken
//   output: a point appears on points in the cycle after its fourth byte is taken
//   stall: while a point waits in the output register and the receiver holds
//   ready low, bytes.ready drops; it stays high when the receiver takes the
//   point in that same cycle
//   reset: parsing restarts at a message head, counters and held attributes
//   clear, the output register empties
`timescale 1ns / 1ps
`default_nettype none
module nested_length_prefixed_point_deframer
    import nlpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    nlpd_byte_if.sink    bytes,
    nlpd_point_if.source points
);

    logic    can_load;
    logic    accept;
    result_t result;

    // a byte is only taken when its possible point has a place to go
    assign bytes.ready = can_load;
    assign accept      = bytes.valid && can_load;

    // header / record / point parse state and point assembly
    nlpd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (bytes.byte_in),
        .result  (result)
    );

    // result register toward the receiver
    nlpd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .result   (result),
        .can_load (can_load),
        .points   (points)
    );

`ifndef SYNTH
    a_point_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.emit) |=> points.valid)
        else $error("completed point did not reach the output register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> (points.valid && !points.ready))
        else $error("byte input stalled with room in the output register");

    a_point_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (points.valid && !points.ready) |=>
            (points.valid && $stable(points.point_x) && $stable(points.point_y)))
        else $error("waiting point word changed before it was taken");
`endif

endmodule
`default_nettype wire

@@ sim/nested_length_prefixed_point_deframer_test.sv @@
// self-checking testbench of the nested length-prefixed point deframer
`timescale 1ns / 1ps
module nested_length_prefixed_point_deframer_test;
    import nlpd_pkg::*;

    // cycles with no word moving on either side before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // receiver hold-off used to fill the block and stall its byte input
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_BYTES = 1100;

    logic clk;
    logic rst_n;

    nlpd_byte_if  byte_ch ();
    nlpd_point_if point_ch ();

    nested_length_prefixed_point_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .points (point_ch)
    );

    // expected decoded points, oldest first
    point_t pending_points[$];
    // payload of the message being built, sent by send_message
    logic [7:0] payload[$];

    int  mismatch_count = 0;
    int  points_checked = 0;
    int  bytes_sent = 0;
    int  messages_sent = 0;
    int  idle_cycles = 0;
    int  hold_request = 0;
    bit  no_gaps = 1'b0;

    // parser state as the block should hold it
    phase_t      parse_phase = PH_MSG_LEN_HI;
    logic [15:0] payload_left = '0;
    logic [15:0] record_left = '0;
    logic [7:0]  kind_held = '0;
    logic [7:0]  size_held = '0;
    logic [7:0]  color_held = '0;
    logic [23:0] coord_bytes = '0;
    logic [1:0]  coord_count = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // start of a point slot: gather another point, skip the leftover bytes,
    // or move on to the next record head once the record is used up
    function automatic phase_t next_point_slot();
        coord_count = '0;
        if (record_left == 0)
            return PH_REC_LEN_HI;
        if (record_left < POINT_BYTES)
            return PH_SKIP;
        return PH_POINT;
    endfunction

    // advance the expected parser by one accepted stream byte; a point whose
    // fourth byte this is goes onto the expected queue
    function automatic void deframe_byte(input logic [7:0] b);
        point_t pt;
        case (parse_phase)
            PH_MSG_LEN_LO:
            begin
                payload_left = payload_left | {8'h00, b};
                parse_phase = PH_MSG_TYPE;
            end
            PH_MSG_TYPE:
            begin
                // an empty payload returns straight to the message head
                parse_phase = (payload_left != 0) ? PH_REC_LEN_HI : PH_MSG_LEN_HI;
            end
            PH_REC_LEN_HI, PH_REC_LEN_LO, PH_REC_TYPE, PH_KIND, PH_SIZE, PH_COLOR,
            PH_POINT, PH_SKIP:
            begin
                // every byte from here on belongs to the message payload
                payload_left = payload_left - 16'd1;
                case (parse_phase)
                    PH_REC_LEN_HI:
                    begin
                        record_left = {b, 8'h00};
                        parse_phase = PH_REC_LEN_LO;
                    end
                    PH_REC_LEN_LO:
                    begin
                        record_left = record_left | {8'h00, b};
                        parse_phase = PH_REC_TYPE;
                    end
                    PH_REC_TYPE:
                    begin
                        // zero-length record goes on to the next record head
                        parse_phase = (record_left != 0) ? PH_KIND : PH_REC_LEN_HI;
                    end
                    PH_KIND:
                    begin
                        record_left = record_left - 16'd1;
                        kind_held = b;
                        parse_phase = (record_left == 0) ? PH_REC_LEN_HI : PH_SIZE;
                    end
                    PH_SIZE:
                    begin
                        record_left = record_left - 16'd1;
                        size_held = b;
                        parse_phase = (record_left == 0) ? PH_REC_LEN_HI : PH_COLOR;
                    end
                    PH_COLOR:
                    begin
                        record_left = record_left - 16'd1;
                        color_held = b;
                        parse_phase = next_point_slot();
                    end
                    PH_POINT:
                    begin
                        record_left = record_left - 16'd1;
                        if (coord_count < HEAD_BYTES)
                        begin
                            coord_bytes = {coord_bytes[15:0], b};
                            coord_count = coord_count + 2'd1;
                            parse_phase = (record_left == 0) ? PH_REC_LEN_HI : PH_POINT;
                        end
                        else
                        begin
                            pt.object_kind = kind_held;
                            pt.obj_size = size_held;
                            pt.obj_color = color_held;
                            pt.point_x = coord_bytes[23:8];
                            pt.point_y = {coord_bytes[7:0], b};
                            // no whole point can follow in the record or the payload
                            pt.last_in_object = (record_left < POINT_BYTES) ||
                                                (payload_left < POINT_BYTES);
                            pt.last_in_message = (payload_left <= record_left);
                            pending_points = {pending_points, pt};
                            parse_phase = next_point_slot();
                        end
                    end
                    default:
                    begin
                        // leftover bytes that cannot fill a point
                        record_left = record_left - 16'd1;
                        parse_phase = (record_left == 0) ? PH_REC_LEN_HI : PH_SKIP;
                    end
                endcase
                // payload used up: whatever record was open is abandoned
                if (payload_left == 0)
                begin
                    parse_phase = PH_MSG_LEN_HI;
                    coord_count = '0;
                end
            end
            default:
            begin
                payload_left = {b, 8'h00};
                parse_phase = PH_MSG_LEN_LO;
                coord_count = '0;
            end
        endcase
    endfunction

    // random byte with the field extremes well represented
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // record head with the given length field, then content_count random bytes
    function automatic void add_record(input int len_field, input int content_count);
        logic [15:0] len;
        len = 16'(len_field);
        payload = {payload, len[15:8]};
        payload = {payload, len[7:0]};
        payload = {payload, rand_byte()};
        repeat (content_count) payload = {payload, rand_byte()};
    endfunction

    // one word on the byte channel; called and returns just after a falling edge
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.byte_in <= value;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        deframe_byte(value);
        bytes_sent++;
        @(negedge clk);
    endtask

    // message head with the given payload length, then that many payload bytes;
    // a length beyond the built payload is padded with random bytes
    task automatic send_message(input int len);
        logic [15:0] outer;
        int i;
        outer = 16'(len);
        send_byte(outer[15:8]);
        send_byte(outer[7:0]);
        send_byte(rand_byte());
        for (i = 0; i < len; i++)
            send_byte(i < payload.size() ? payload[i] : rand_byte());
        payload.delete();
        messages_sent++;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_empty_payload();
        send_message(0);
    endtask

    // most negative and most positive coordinates, extreme attributes, and
    // two leftover bytes after the last whole point
    task automatic test_point_extremes();
        payload = '{8'h00, 8'h0d, 8'ha5, 8'hff, 8'h00, 8'hff,
                    8'h80, 8'h00, 8'h7f, 8'hff,
                    8'h7f, 8'hff, 8'h80, 8'h00,
                    8'h55, 8'haa};
        send_message(payload.size());
    endtask

    // zero-length record, record too short for a point, then one point
    task automatic test_short_records();
        payload = '{8'h00, 8'h00, 8'h01,
                    8'h00, 8'h02, 8'h02, 8'h11, 8'h22,
                    8'h00, 8'h07, 8'h03, 8'h33, 8'h44, 8'h55,
                    8'h01, 8'h02, 8'h03, 8'h04};
        send_message(payload.size());
    endtask

    // payload ends in the middle of a point; the next message must start clean
    // and its point is flagged last because the payload runs out
    task automatic test_payload_overrun();
        add_record(20, 5);
        send_message(8);
        add_record(11, 11);
        send_message(12);
    endtask

    // receiver holds off long enough for the output register to fill and the
    // byte input to stall while points keep coming
    task automatic test_output_stall();
        hold_request = LONG_HOLD;
        add_record(3 + 4 * 15, 3 + 4 * 15);
        send_message(payload.size());
    endtask

    // mostly well-formed messages with random content, plus records with
    // bogus lengths and payload lengths that are short, long or zero
    task automatic random_message();
        int n_rec;
        int sel;
        int clen;
        int outer;
        n_rec = $urandom_range(1, 3);
        repeat (n_rec)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                clen = 3 + 4 * $urandom_range(0, 4);
                if ($urandom_range(0, 2) == 0)
                    clen += $urandom_range(1, 3);
                add_record(clen, clen);
            end
            else if (sel < 9)
            begin
                clen = $urandom_range(0, 6);
                add_record(clen, clen);
            end
            else
                add_record($urandom_range(0, 65535), $urandom_range(0, 12));
        end
        sel = $urandom_range(0, 19);
        if (sel < 16)
            outer = payload.size();
        else if (sel < 18)
            outer = $urandom_range(0, payload.size());
        else if (sel < 19)
            outer = payload.size() + $urandom_range(1, 8);
        else
            outer = 0;
        send_message(outer);
    endtask

    task automatic test_random_messages();
        int goal;
        goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < goal)
        begin
            // now and then a message goes through with no idling on either side
            no_gaps = ($urandom_range(0, 5) == 0);
            random_message();
        end
        no_gaps = 1'b0;
    endtask

    // point receiver: random stall before each word, a long hold when asked
    initial
    begin : point_receiver
        int wait_cycles;
        point_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request != 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 14);
            if (wait_cycles != 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            point_ch.ready <= 1'b1;
            @(posedge clk);
            while (!point_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // every accepted point word against the oldest expected point
    always @(posedge clk)
    begin : point_checker
        point_t want;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $error("point word with none expected: x %0d, y %0d",
                       point_ch.point_x, point_ch.point_y);
                mismatch_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                report_field("object_kind", want.object_kind, point_ch.object_kind);
                report_field("obj_size", want.obj_size, point_ch.obj_size);
                report_field("obj_color", want.obj_color, point_ch.obj_color);
                report_field("point_x", want.point_x, point_ch.point_x);
                report_field("point_y", want.point_y, point_ch.point_y);
                report_field("last_in_object", want.last_in_object,
                             point_ch.last_in_object);
                report_field("last_in_message", want.last_in_message,
                             point_ch.last_in_message);
                points_checked++;
            end
        end
    end

    // watchdog: too long with no word moving on either channel means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (point_ch.valid && point_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d points outstanding",
                     STALL_LIMIT, pending_points.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.byte_in <= 8'h00;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_payload();
        test_point_extremes();
        test_short_records();
        test_payload_overrun();
        test_output_stall();
        test_random_messages();
        byte_ch.valid <= 1'b0;

        // drain, then wait for any stray word to show up
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d stream bytes in %0d messages, checked %0d points",
                 bytes_sent, messages_sent, points_checked);
        $display("%0d mismatches seen", mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/nlpd_pkg.sv
src/nlpd_byte_if.sv
src/nlpd_point_if.sv
src/nlpd_parser.sv
src/nlpd_out_reg.sv
src/nested_length_prefixed_point_deframer.sv
sim/nested_length_prefixed_point_deframer_test.sv
